// ===== rtl/core/dae_pkg.sv =====
// Shared types, constants and helpers of the DCTCP alpha estimator.
`default_nettype none
package dae_pkg;

    // Q16 fixed point: 65536 is 1.0
    localparam logic [16:0] Q16_ONE    = 17'd65536;
    localparam logic [16:0] GAIN_RESET = 17'd4096;
    localparam logic [15:0] SEG_RESET  = 16'd536;

    // command queue between front and back
    localparam int QUEUE_DEPTH = 4;

    // quotient bits of ratio = ecn * 2^16 / total
    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // configuration port
    localparam int ADDR_W = 3;
    localparam logic REG_GAIN = 1'b0;
    localparam logic REG_SEG  = 1'b1;

    typedef enum logic [1:0] {
        KIND_ACK  = 2'd0,
        KIND_SEND = 2'd1,
        KIND_RETX = 2'd2,
        KIND_DECR = 2'd3
    } t_kind;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] seq_value;
        logic [31:0] mark_value;
        logic [15:0] length;
        logic        ece_flag;
        logic        syn_flag;
        logic [31:0] window_bytes;
    } t_in_item;

    typedef struct packed {
        logic [16:0] alpha_value;
        logic        alpha_updated;
        logic [31:0] new_cwnd;
        logic [31:0] new_ssthresh;
        logic        window_valid;
    } t_out_item;

    // classified command, as stored in the queue
    typedef struct packed {
        t_kind       kind;
        logic [31:0] seq;
        logic [31:0] acked;
        logic        acked_pos;
        logic        ece;
        logic        syn;
        logic [31:0] send_mark;
        logic [31:0] win;
    } t_cmd;

    // wrapping sequence compare: a strictly after b
    function automatic logic seq_after(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    // saturating 32-bit add
    function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/dae_front.sv =====
// Front end: accepts input items and classifies them into queue commands.
`default_nettype none
module dae_front (
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire dae_pkg::t_in_item i_item,
    input  wire logic              i_full,
    output logic                   o_push,
    output dae_pkg::t_cmd          o_cmd
);

    logic [31:0] end_seq;

    // handshake toward the queue
    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    // stateless precomputation per kind
    always_comb begin
        end_seq = i_item.seq_value + {16'd0, i_item.length};

        o_cmd.kind      = dae_pkg::t_kind'(i_item.kind);
        o_cmd.seq       = i_item.seq_value;
        o_cmd.acked     = i_item.seq_value - i_item.mark_value;
        o_cmd.acked_pos = (o_cmd.acked != 32'd0) && !o_cmd.acked[31];
        o_cmd.ece       = i_item.ece_flag;
        o_cmd.syn       = i_item.syn_flag;
        // end of sent data, raised to the transmitted mark if that is later
        o_cmd.send_mark = dae_pkg::seq_after(i_item.mark_value, end_seq) ?
                          i_item.mark_value : end_seq;
        o_cmd.win       = i_item.window_bytes;
    end

endmodule
`default_nettype wire

// ===== rtl/core/dae_cmd_fifo.sv =====
// Short command queue decoupling the front end from the execution back end.
`default_nettype none
module dae_cmd_fifo #(
    parameter int DEPTH = dae_pkg::QUEUE_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire dae_pkg::t_cmd i_push_data,
    output logic               o_full,
    output logic               o_pop_valid,
    output dae_pkg::t_cmd      o_pop_data,
    input  wire logic          i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    dae_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_pop_valid = (r_count != '0);
    assign o_pop_data  = r_mem[r_rd_ptr];
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && o_pop_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/dae_back.sv =====
// Back end: estimator state, radix-2 ratio divider, shared multiplier, result register.
`default_nettype none
module dae_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic [16:0]   i_gain,
    input  wire logic [15:0]   i_seg,
    input  wire logic          i_cmd_valid,
    input  wire dae_pkg::t_cmd i_cmd,
    output logic               o_cmd_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output dae_pkg::t_out_item o_result
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_EXEC = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_MULA = 7'b0001000,
        S_MULB = 7'b0010000,
        S_WIN  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state                       r_state, n_state;
    dae_pkg::t_cmd                r_cmd, n_cmd;
    logic [16:0]                  r_alpha, n_alpha;
    logic [31:0]                  r_ecn, n_ecn;
    logic [31:0]                  r_total, n_total;
    logic [31:0]                  r_barrier, n_barrier;
    logic [31:0]                  r_highest, n_highest;
    logic                         r_upd, n_upd;
    logic [32:0]                  r_rem, n_rem;
    logic [31:0]                  r_den, n_den;
    logic [16:0]                  r_quot, n_quot;
    logic [dae_pkg::DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [33:0]                  r_acc, n_acc;
    logic [31:0]                  r_red, n_red;
    logic                         r_out_valid, n_out_valid;
    dae_pkg::t_out_item           r_out, n_out;

    logic [16:0] gain_eff;
    logic [16:0] ratio;
    logic [31:0] mul_a;
    logic [17:0] mul_b;
    logic [49:0] prod;
    logic [31:0] add_total, add_ecn;
    logic        div_ge;
    logic [32:0] div_diff;
    logic [34:0] acc_sum;
    logic [18:0] acc_shift;
    logic [31:0] seg_ext, two_seg;
    logic        out_free;

    assign o_valid   = r_out_valid;
    assign o_result  = r_out;
    assign out_free  = !r_out_valid || i_ready;
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    // gain above one acts as one; ratio capped at one
    assign gain_eff = (i_gain > dae_pkg::Q16_ONE) ? dae_pkg::Q16_ONE : i_gain;
    assign ratio    = (r_quot > dae_pkg::Q16_ONE) ? dae_pkg::Q16_ONE : r_quot;

    // shared multiplier operand select
    always_comb begin
        case (r_state)
            S_MULA: begin
                mul_a = {15'd0, dae_pkg::Q16_ONE - gain_eff};
                mul_b = {1'b0, r_alpha};
            end
            S_MULB: begin
                mul_a = {15'd0, gain_eff};
                mul_b = {1'b0, ratio};
            end
            default: begin
                mul_a = r_cmd.win;
                mul_b = 18'd131072 - {1'b0, r_alpha};
            end
        endcase
    end
    assign prod = {18'd0, mul_a} * {32'd0, mul_b};

    // divider step and alpha rounding
    assign div_ge    = (r_rem >= {1'b0, r_den});
    assign div_diff  = r_rem - {1'b0, r_den};
    assign acc_sum   = {1'b0, r_acc} + {1'b0, prod[33:0]} + 35'd32768;
    assign acc_shift = acc_sum[34:16];
    assign add_total = dae_pkg::sat_add(r_total, r_cmd.acked);
    assign add_ecn   = dae_pkg::sat_add(r_ecn, r_cmd.acked);
    assign seg_ext   = {16'd0, i_seg};
    assign two_seg   = {15'd0, i_seg, 1'b0};

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_alpha     = r_alpha;
        n_ecn       = r_ecn;
        n_total     = r_total;
        n_barrier   = r_barrier;
        n_highest   = r_highest;
        n_upd       = r_upd;
        n_rem       = r_rem;
        n_den       = r_den;
        n_quot      = r_quot;
        n_cnt       = r_cnt;
        n_acc       = r_acc;
        n_red       = r_red;
        n_out_valid = r_out_valid && !i_ready;
        n_out       = r_out;

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd   = i_cmd;
                    n_upd   = 1'b0;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_DONE;
                case (r_cmd.kind)
                    dae_pkg::KIND_ACK: begin
                        if (!r_cmd.syn) begin
                            // count newly acked bytes
                            if (r_cmd.acked_pos) begin
                                n_total = add_total;
                                if (r_cmd.ece) begin
                                    n_ecn = add_ecn;
                                end
                            end
                            // window boundary passed: start alpha update
                            if (dae_pkg::seq_after(r_cmd.seq, r_barrier)) begin
                                n_barrier = r_highest;
                                n_upd     = 1'b1;
                                n_rem     = {1'b0, n_ecn};
                                n_den     = (n_total == 32'd0) ? 32'd1 : n_total;
                                n_quot    = '0;
                                n_cnt     = dae_pkg::DIV_CNT_W'(dae_pkg::DIV_STEPS - 1);
                                n_ecn     = '0;
                                n_total   = '0;
                                n_state   = S_DIV;
                            end
                        end
                    end
                    dae_pkg::KIND_SEND: begin
                        if (dae_pkg::seq_after(r_cmd.send_mark, r_highest)) begin
                            n_highest = r_cmd.send_mark;
                        end
                    end
                    dae_pkg::KIND_RETX: begin
                        n_barrier = r_cmd.seq;
                        n_highest = r_cmd.seq;
                    end
                    default: begin
                        n_state = S_WIN;
                    end
                endcase
            end
            S_DIV: begin
                // one quotient bit per cycle
                n_quot = {r_quot[15:0], div_ge};
                n_rem  = {(div_ge ? div_diff[31:0] : r_rem[31:0]), 1'b0};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_MULA;
                end
            end
            S_MULA: begin
                n_acc   = prod[33:0];
                n_state = S_MULB;
            end
            S_MULB: begin
                n_alpha = (acc_shift > {2'd0, dae_pkg::Q16_ONE}) ?
                          dae_pkg::Q16_ONE : acc_shift[16:0];
                n_state = S_DONE;
            end
            S_WIN: begin
                n_red   = prod[48:17];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid             = 1'b1;
                    n_out.alpha_value       = r_alpha;
                    n_out.alpha_updated     = r_upd;
                    if (r_cmd.kind == dae_pkg::KIND_DECR) begin
                        n_out.new_cwnd     = (r_red > seg_ext) ? r_red : seg_ext;
                        n_out.new_ssthresh = (r_red > two_seg) ? r_red : two_seg;
                        n_out.window_valid = 1'b1;
                    end else begin
                        n_out.new_cwnd     = '0;
                        n_out.new_ssthresh = '0;
                        n_out.window_valid = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control and estimator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_alpha     <= dae_pkg::Q16_ONE;
            r_ecn       <= '0;
            r_total     <= '0;
            r_barrier   <= '0;
            r_highest   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_alpha     <= n_alpha;
            r_ecn       <= n_ecn;
            r_total     <= n_total;
            r_barrier   <= n_barrier;
            r_highest   <= n_highest;
            r_out_valid <= n_out_valid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_upd  <= n_upd;
        r_rem  <= n_rem;
        r_den  <= n_den;
        r_quot <= n_quot;
        r_cnt  <= n_cnt;
        r_acc  <= n_acc;
        r_red  <= n_red;
        r_out  <= n_out;
    end

`ifndef SYNTHESIS
    // alpha stays within Q16 one
    a_alpha_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_alpha <= dae_pkg::Q16_ONE)
        else $error("alpha above one");

    // echoed bytes never exceed acked bytes
    a_ecn_le_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ecn <= r_total)
        else $error("ecn count above total count");

    // a finished command with a free output register yields a result
    a_done_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && out_free) |=> (r_out_valid && r_state == S_IDLE))
        else $error("result not delivered from done state");

    // no command is taken while a previous one is in progress
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_pop |=> (r_state == S_EXEC))
        else $error("pop outside idle");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/dctcp_alpha_estimator_unit.sv =====
// Top level of the DCTCP alpha estimator: configuration registers and unit wiring.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------
//  input    | in        | i_valid / o_ready         | i_item   (t_in_item)
//  result   | out       | o_valid / i_ready         | o_result (t_out_item)
//  config   | in        | psel, penable, pwrite     | paddr, pwdata, prdata
//
// One result per item. In the back end an ACK that passes the barrier runs
// the radix-2 ratio divider (17 quotient bits, one per cycle) and makes two
// passes through the shared multiplier; other ACKs, sends and retransmits go
// straight to the result, a decrease uses one. The front end queues up to
// DEPTH classified items meanwhile. Reset is synchronous and active low and
// clears the estimator state and queue; no clearing pass is needed. A stalled
// result holds in the output register while the back end finishes its command.
`default_nettype none
module dctcp_alpha_estimator_unit #(
    parameter int DEPTH = dae_pkg::QUEUE_DEPTH
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire dae_pkg::t_in_item          i_item,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output dae_pkg::t_out_item              o_result,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [dae_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic [16:0]   r_gain;
    logic [15:0]   r_seg;
    logic          cfg_wr;
    logic          push, full, pop_valid, pop;
    dae_pkg::t_cmd push_cmd, pop_cmd;

    // configuration registers, register select on the word address bit
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain <= dae_pkg::GAIN_RESET;
            r_seg  <= dae_pkg::SEG_RESET;
        end else if (cfg_wr) begin
            if (paddr[2] == dae_pkg::REG_GAIN) begin
                r_gain <= pwdata[16:0];
            end else begin
                r_seg <= pwdata[15:0];
            end
        end
    end

    assign prdata = (paddr[2] == dae_pkg::REG_SEG) ? {16'd0, r_seg} : {15'd0, r_gain};

    dae_front u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    dae_cmd_fifo #(
        .DEPTH (DEPTH)
    ) u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_cmd),
        .o_full      (full),
        .o_pop_valid (pop_valid),
        .o_pop_data  (pop_cmd),
        .i_pop       (pop)
    );

    dae_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_gain      (r_gain),
        .i_seg       (r_seg),
        .i_cmd_valid (pop_valid),
        .i_cmd       (pop_cmd),
        .o_cmd_pop   (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result)
    );

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the DCTCP alpha estimator: directed and random traffic.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RUN_LIMIT = 400000;
    localparam int unsigned PRINT_CAP = 100;
    localparam int NUM_PHASES = 8;
    localparam int CHUNK_ITEMS = 70;

    // DUT ports
    logic                       i_clk    = 1'b0;
    logic                       i_rst_n  = 1'b0;
    logic                       i_valid  = 1'b0;
    logic                       o_ready;
    dae_pkg::t_in_item          i_item   = '0;
    logic                       o_valid;
    logic                       i_ready  = 1'b0;
    dae_pkg::t_out_item         o_result;
    logic                       psel     = 1'b0;
    logic                       penable  = 1'b0;
    logic                       pwrite   = 1'b0;
    logic [dae_pkg::ADDR_W-1:0] paddr    = '0;
    logic [31:0]                pwdata   = '0;
    logic [31:0]                prdata;
    logic                       pready;

    dctcp_alpha_estimator_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 i_clk = ~i_clk;

    // estimator state as the block should hold it
    logic [16:0] est_gain;
    logic [15:0] est_seg;
    logic [16:0] alpha_est;
    logic [31:0] ecn_bytes;
    logic [31:0] tot_bytes;
    logic [31:0] barrier_seq;
    logic [31:0] top_sent_seq;

    dae_pkg::t_in_item  traffic_q[$];
    dae_pkg::t_out_item outcome_q[$];

    int unsigned fail_count  = 0;
    int unsigned result_idx  = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap    = 0;
    int unsigned recv_wait   = 0;
    bit          idle_on     = 1'b1;
    int unsigned ece_pct     = 50;

    // sender-side sequence space used to build well-formed traffic
    logic [31:0] flow_una;
    logic [31:0] flow_nxt;

    // a strictly after b, modulo 2^32
    function automatic bit wraps_past(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic logic [31:0] add_clamped(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // alpha = (1-g)*alpha + g*ecn/total, rounded to nearest
    function automatic logic [16:0] fold_alpha();
        logic [63:0] g, den, ratio, acc, a64;
        g     = (est_gain > dae_pkg::Q16_ONE) ? 64'(dae_pkg::Q16_ONE) : 64'(est_gain);
        den   = (tot_bytes != 32'd0) ? 64'(tot_bytes) : 64'd1;
        ratio = {16'd0, ecn_bytes, 16'd0} / den;
        if (ratio > 64'd65536)
            ratio = 64'd65536;
        a64 = 64'(alpha_est);
        acc = (64'd65536 - g) * a64 + g * ratio + 64'd32768;
        acc = acc >> 16;
        if (acc > 64'd65536)
            acc = 64'd65536;
        return acc[16:0];
    endfunction

    // applies one item to the estimator state and returns its result
    function automatic dae_pkg::t_out_item dctcp_outcome(input dae_pkg::t_in_item it);
        dae_pkg::t_out_item r;
        logic [31:0]        acked, reach, cut, dbl;
        logic [63:0]        w64, f64, prod;
        r = '0;
        case (it.kind)
            dae_pkg::KIND_ACK: begin
                if (!it.syn_flag) begin
                    acked = it.seq_value - it.mark_value;
                    if (acked != 32'd0 && !acked[31]) begin
                        tot_bytes = add_clamped(tot_bytes, acked);
                        if (it.ece_flag)
                            ecn_bytes = add_clamped(ecn_bytes, acked);
                    end
                    if (wraps_past(it.seq_value, barrier_seq)) begin
                        barrier_seq     = top_sent_seq;
                        alpha_est       = fold_alpha();
                        ecn_bytes       = '0;
                        tot_bytes       = '0;
                        r.alpha_updated = 1'b1;
                    end
                end
            end
            dae_pkg::KIND_SEND: begin
                reach = it.seq_value + {16'd0, it.length};
                if (wraps_past(it.mark_value, reach))
                    reach = it.mark_value;
                if (wraps_past(reach, top_sent_seq))
                    top_sent_seq = reach;
            end
            dae_pkg::KIND_RETX: begin
                barrier_seq  = it.seq_value;
                top_sent_seq = it.seq_value;
            end
            default: begin
                // W*(1-alpha/2), floors at one and two segments
                w64  = 64'(it.window_bytes);
                f64  = 64'd131072 - 64'(alpha_est);
                prod = w64 * f64;
                cut  = prod[48:17];
                dbl  = {15'd0, est_seg, 1'b0};
                r.new_cwnd     = (cut > {16'd0, est_seg}) ? cut : {16'd0, est_seg};
                r.new_ssthresh = (cut > dbl) ? cut : dbl;
                r.window_valid = 1'b1;
            end
        endcase
        r.alpha_value = alpha_est;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_CAP)
            $display("result %0d: %s got %0h expected %0h", result_idx, what, got, want);
        fail_count++;
    endtask

    task automatic check_outcome(input dae_pkg::t_out_item got);
        dae_pkg::t_out_item want;
        result_idx++;
        if (outcome_q.size() == 0) begin
            report_mismatch("result with nothing pending", 32'd0, 32'd0);
            return;
        end
        want = outcome_q.pop_front();
        if (got.alpha_value !== want.alpha_value)
            report_mismatch("alpha_value", 32'(got.alpha_value), 32'(want.alpha_value));
        if (got.alpha_updated !== want.alpha_updated)
            report_mismatch("alpha_updated", 32'(got.alpha_updated),
                            32'(want.alpha_updated));
        if (got.new_cwnd !== want.new_cwnd)
            report_mismatch("new_cwnd", got.new_cwnd, want.new_cwnd);
        if (got.new_ssthresh !== want.new_ssthresh)
            report_mismatch("new_ssthresh", got.new_ssthresh, want.new_ssthresh);
        if (got.window_valid !== want.window_valid)
            report_mismatch("window_valid", 32'(got.window_valid), 32'(want.window_valid));
    endtask

    // random per-item wait; zero runs give back-to-back stretches
    function automatic int unsigned pick_gap();
        if (!idle_on || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    function automatic dae_pkg::t_in_item mk(input dae_pkg::t_kind k, input logic [31:0] seq,
                                             input logic [31:0] mark, input logic [15:0] len,
                                             input logic ece, input logic syn,
                                             input logic [31:0] win);
        dae_pkg::t_in_item it;
        it.kind         = k;
        it.seq_value    = seq;
        it.mark_value   = mark;
        it.length       = len;
        it.ece_flag     = ece;
        it.syn_flag     = syn;
        it.window_bytes = win;
        return it;
    endfunction

    function automatic dae_pkg::t_in_item random_item();
        dae_pkg::t_in_item it;
        it.kind         = 2'($urandom_range(0, 3));
        it.seq_value    = $urandom();
        it.mark_value   = $urandom();
        it.length       = 16'($urandom());
        it.ece_flag     = 1'($urandom());
        it.syn_flag     = 1'($urandom());
        it.window_bytes = $urandom();
        return it;
    endfunction

    // mostly a coherent send/ack flow, some retransmits, decreases and noise
    function automatic dae_pkg::t_in_item make_traffic();
        dae_pkg::t_in_item it;
        int unsigned       r;
        logic [31:0]       span;
        it = random_item();
        r  = $urandom_range(0, 99);
        if (r < 12) begin
            return it;
        end else if (r < 45) begin
            it.kind      = dae_pkg::KIND_SEND;
            it.seq_value = flow_nxt;
            it.length    = ($urandom_range(0, 7) == 0) ? 16'($urandom())
                                                       : 16'($urandom_range(0, 1500));
            case ($urandom_range(0, 7))
                0: it.mark_value = flow_nxt + {16'd0, it.length} + $urandom_range(1, 2000);
                1: it.mark_value = $urandom();
                default: it.mark_value = flow_nxt + {16'd0, it.length};
            endcase
            flow_nxt = flow_nxt + {16'd0, it.length};
            if (wraps_past(it.mark_value, flow_nxt) &&
                (it.mark_value - flow_nxt) < 32'd4096)
                flow_nxt = it.mark_value;
        end else if (r < 85) begin
            it.kind      = dae_pkg::KIND_ACK;
            span         = flow_nxt - flow_una;
            it.seq_value = (span == 32'd0 || span[31]) ? flow_una
                                                       : flow_una + $urandom_range(1, span);
            if ($urandom_range(0, 7) == 0) begin
                // stale or duplicate ack
                it.mark_value = it.seq_value + $urandom_range(0, 100);
            end else begin
                it.mark_value = flow_una;
                flow_una      = it.seq_value;
            end
            it.ece_flag = ($urandom_range(0, 99) < ece_pct);
            it.syn_flag = ($urandom_range(0, 24) == 0);
        end else if (r < 90) begin
            it.kind      = dae_pkg::KIND_RETX;
            it.seq_value = flow_una;
            flow_nxt     = flow_una;
        end else begin
            it.kind = dae_pkg::KIND_DECR;
            case ($urandom_range(0, 3))
                0: it.window_bytes = $urandom_range(0, 4000);
                1: it.window_bytes = 32'hFFFF_FFFF;
                default: it.window_bytes = $urandom();
            endcase
        end
        return it;
    endfunction

    // APB write: setup then access; the register takes the value at the access edge
    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == dae_pkg::REG_GAIN)
            est_gain = value[16:0];
        else
            est_seg = value[15:0];
    endtask

    // sender holds off until every result is back; sampled between edges
    task automatic drain();
        @(negedge i_clk);
        while (traffic_q.size() != 0 || i_valid || outcome_q.size() != 0)
            @(negedge i_clk);
    endtask

    // input driver: one transfer per item, random gap after each
    always @(posedge i_clk) begin : drive_items
        logic next_valid;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            send_gap   = 0;
        end else begin
            next_valid = i_valid;
            if (i_valid && o_ready) begin
                outcome_q.push_back(dctcp_outcome(i_item));
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap != 0) begin
                    send_gap--;
                end else if (traffic_q.size() != 0) begin
                    i_item     <= traffic_q.pop_front();
                    next_valid = 1'b1;
                    send_gap   = pick_gap();
                end
            end
        end
        i_valid <= next_valid;
    end

    // result monitor with random back-pressure after each transfer
    always @(posedge i_clk) begin : watch_results
        logic next_ready;
        if (!i_rst_n) begin
            next_ready = 1'b0;
            recv_wait  = 0;
        end else begin
            next_ready = i_ready;
            if (o_valid && i_ready) begin
                check_outcome(o_result);
                recv_wait  = pick_gap();
                next_ready = (recv_wait == 0);
            end else if (!i_ready) begin
                if (recv_wait != 0)
                    recv_wait--;
                if (recv_wait == 0)
                    next_ready = 1'b1;
            end
        end
        i_ready <= next_ready;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("** dctcp_alpha_estimator_unit: FAILED **");
            $finish;
        end
    end

    initial begin
        logic [31:0] gains [NUM_PHASES];
        logic [31:0] segs  [NUM_PHASES];
        logic [31:0] base;

        // reset values of state and registers
        est_gain     = dae_pkg::GAIN_RESET;
        est_seg      = dae_pkg::SEG_RESET;
        alpha_est    = dae_pkg::Q16_ONE;
        ecn_bytes    = '0;
        tot_bytes    = '0;
        barrier_seq  = '0;
        top_sent_seq = '0;

        gains = '{32'd4096, 32'd65536, 32'd0, 32'd131071,
                  $urandom_range(0, 131071), 32'd1, 32'd32768, 32'd4096};
        segs  = '{32'd536, 32'd65535, 32'd1, 32'd0,
                  $urandom_range(0, 65535), 32'd1460, 32'd9000, 32'd536};

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: window extremes, SYN, send marks, stale acks, saturation, wrap
        traffic_q.push_back(mk(dae_pkg::KIND_DECR, 32'h0, 32'h0, 16'h0, 1'b0, 1'b0,
                               32'hFFFF_FFFF));
        traffic_q.push_back(mk(dae_pkg::KIND_DECR, 32'h0, 32'h0, 16'h0, 1'b0, 1'b0, 32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_DECR, 32'h0, 32'h0, 16'h0, 1'b0, 1'b0,
                               32'd1000));
        traffic_q.push_back(mk(dae_pkg::KIND_ACK, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 1'b1, 1'b1,
                               32'hFFFF_FFFF));
        traffic_q.push_back(mk(dae_pkg::KIND_SEND, 32'd100, 32'h0, 16'hFFFF, 1'b0, 1'b0,
                               32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_SEND, 32'h10, 32'h20_0000, 16'h10, 1'b1, 1'b1,
                               32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_ACK, 32'd5, 32'd10, 16'h0, 1'b1, 1'b0, 32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_ACK, 32'h3000, 32'h3000, 16'h0, 1'b1, 1'b0,
                               32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_RETX, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF,
                               1'b1, 1'b1, 32'hFFFF_FFFF));
        repeat (3)
            traffic_q.push_back(mk(dae_pkg::KIND_ACK, 32'h7FFF_FFFF, 32'h0, 16'h0, 1'b1,
                                   1'b0, 32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_ACK, 32'h8000_0000, 32'h0, 16'h0, 1'b1, 1'b0,
                               32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_ACK, 32'h8000_0001, 32'h8000_0000, 16'h0, 1'b0,
                               1'b0, 32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_DECR, 32'h0, 32'h0, 16'h0, 1'b0, 1'b0,
                               32'h1234_5678));
        traffic_q.push_back(mk(dae_pkg::KIND_SEND, 32'hFFFF_FF00, 32'h0, 16'h200, 1'b0, 1'b0,
                               32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_RETX, 32'hFFFF_FFF0, 32'h0, 16'h0, 1'b0, 1'b0,
                               32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_SEND, 32'hFFFF_FFF0, 32'h0, 16'h20, 1'b0, 1'b0,
                               32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_ACK, 32'h8, 32'hFFFF_FFF0, 16'h0, 1'b1, 1'b0,
                               32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_ACK, 32'h10, 32'h8, 16'h0, 1'b0, 1'b0, 32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_ACK, 32'h11, 32'h10, 16'h0, 1'b1, 1'b0, 32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_DECR, 32'h0, 32'h0, 16'h0, 1'b0, 1'b0,
                               32'hFFFF_FFFF));
        traffic_q.push_back(mk(dae_pkg::KIND_SEND, 32'h11, 32'h11, 16'h0, 1'b0, 1'b0, 32'h0));
        traffic_q.push_back(mk(dae_pkg::KIND_DECR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
                               1'b1, 1'b1, 32'd535));
        drain();

        // random phases, each under its own register setting
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph != 0) begin
                write_reg(dae_pkg::REG_GAIN, gains[ph]);
                write_reg(dae_pkg::REG_SEG, segs[ph]);
            end
            idle_on = (ph % 3) != 2;
            ece_pct = $urandom_range(0, 100);
            base    = (ph % 2 == 1) ? 32'hFFFF_8000 + $urandom_range(0, 4095) : $urandom();
            flow_una = base;
            flow_nxt = base;
            traffic_q.push_back(mk(dae_pkg::KIND_RETX, base, 32'h0, 16'h0, 1'b0, 1'b0,
                                   32'h0));
            for (int chunk = 0; chunk < 2; chunk++) begin
                repeat (CHUNK_ITEMS)
                    traffic_q.push_back(make_traffic());
                drain();
            end
        end

        // let any stray result show up
        repeat (30) @(posedge i_clk);
        if (fail_count == 0)
            $display("** dctcp_alpha_estimator_unit: PASSED **");
        else
            $display("** dctcp_alpha_estimator_unit: FAILED **");
        $finish;
    end

endmodule
